@@ hdl/ipatp_pkg.sv @@
package ipatp_pkg;

  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [9:0] OctetMax  = 10'd255;

  // Flag bit positions.
  localparam int FlFailed = 0;
  localparam int FlColon  = 1;
  localparam int FlDot    = 2;
  localparam int FlDecBad = 3;

  typedef enum logic [1:0] {
    CP_PIECE  = 2'd0,
    CP_LEAD   = 2'd1,
    CP_CLOSED = 2'd2,
    CP_GAP    = 2'd3
  } colon_phase_t;

  typedef enum logic [1:0] {
    TP_LEAD  = 2'd0,
    TP_BODY  = 2'd1,
    TP_TRAIL = 2'd2
  } text_phase_t;

  typedef struct packed {
    logic [7:0][15:0] head_groups;
    logic [7:0][15:0] tail_groups;
    logic [3:0]       head_fill;
    logic [3:0]       tail_fill;
    logic             gap_seen;
    logic [15:0]      group_value;
    logic [2:0]       group_digits;
    logic [3:0][7:0]  dotted_octets;
    logic [9:0]       octet_value;
    logic [1:0]       octet_digits;
    logic [1:0]       dot_total;
    colon_phase_t     colon_phase;
    text_phase_t      text_phase;
    logic [3:0]       flags;
  } parse_state_t;

endpackage

@@ hdl/ipatp_parse.sv @@
module ipatp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            text_char,
  input  logic                  char_present,
  input  logic                  end_of_text,
  output ipatp_pkg::parse_state_t final_state
);
  import ipatp_pkg::*;

  parse_state_t st_r, st_nxt, upd;

  always_comb begin
    logic       first;
    logic [4:0] hex;
    logic       hex_ok;
    logic [3:0] dval;
    upd   = st_r;
    first = 1'b0;
    hex   = '0;
    hex_ok = 1'b0;
    dval  = text_char[3:0];
    if (text_char inside {[CharZero:CharNine]}) begin
      hex_ok = 1'b1;
      hex    = {1'b0, text_char[3:0]};
    end else if (text_char inside {[CharLowA:8'h66]}) begin
      hex_ok = 1'b1;
      hex    = 5'(text_char - CharLowA + 8'd10);
    end else if (text_char inside {[CharUpA:8'h46]}) begin
      hex_ok = 1'b1;
      hex    = 5'(text_char - CharUpA + 8'd10);
    end
    if (char_present) begin
      if (text_char inside {8'h20, [8'h09:8'h0d]}) begin
        if (st_r.text_phase == TP_BODY) upd.text_phase = TP_TRAIL;
      end else if (st_r.text_phase == TP_TRAIL) begin
        upd.flags[FlFailed] = 1'b1;
      end else begin
        first = (st_r.text_phase == TP_LEAD);
        upd.text_phase = TP_BODY;
        if (text_char == CharColon) begin
          upd.flags[FlColon] = 1'b1;
          if (first) begin
            upd.colon_phase = CP_LEAD;
          end else begin
            case (st_r.colon_phase)
              CP_LEAD: begin
                upd.gap_seen = 1'b1;
                upd.colon_phase = CP_GAP;
              end
              CP_CLOSED: begin
                if (st_r.gap_seen) upd.flags[FlFailed] = 1'b1;
                upd.gap_seen = 1'b1;
                upd.colon_phase = CP_GAP;
              end
              CP_GAP: upd.flags[FlFailed] = 1'b1;
              default: begin
                if (st_r.flags[FlDot]) begin
                  upd.flags[FlFailed] = 1'b1;
                end else if (st_r.gap_seen) begin
                  if (st_r.tail_fill[3]) upd.flags[FlFailed] = 1'b1;
                  else begin
                    upd.tail_groups[st_r.tail_fill[2:0]] = st_r.group_value;
                    upd.tail_fill = st_r.tail_fill + 4'd1;
                  end
                end else begin
                  if (st_r.head_fill[3]) upd.flags[FlFailed] = 1'b1;
                  else begin
                    upd.head_groups[st_r.head_fill[2:0]] = st_r.group_value;
                    upd.head_fill = st_r.head_fill + 4'd1;
                  end
                end
                upd.colon_phase = CP_CLOSED;
              end
            endcase
          end
          upd.group_value   = '0;
          upd.group_digits  = '0;
          upd.octet_value   = '0;
          upd.octet_digits  = '0;
          upd.dot_total     = '0;
          upd.flags[FlDot]    = 1'b0;
          upd.flags[FlDecBad] = 1'b0;
        end else begin
          if (st_r.colon_phase == CP_LEAD) upd.flags[FlFailed] = 1'b1;
          upd.colon_phase = CP_PIECE;
          // Hex group collection.
          if (text_char == CharDot) begin
            upd.flags[FlDot] = 1'b1;
          end else if (!hex_ok) begin
            upd.flags[FlFailed] = 1'b1;
          end else if (!st_r.flags[FlDot]) begin
            if (st_r.group_digits >= 3'd4) upd.flags[FlFailed] = 1'b1;
            else begin
              upd.group_value  = {st_r.group_value[11:0], hex[3:0]};
              upd.group_digits = st_r.group_digits + 3'd1;
            end
          end
          // Dotted decimal collection runs alongside.
          if (text_char inside {[CharZero:CharNine]}) begin
            if (st_r.octet_digits == 2'd3 ||
                (st_r.octet_digits == 2'd1 && st_r.octet_value == '0)) begin
              upd.flags[FlDecBad] = 1'b1;
            end else begin
              upd.octet_value  = 10'(st_r.octet_value * 10'd10 + {6'd0, dval});
              upd.octet_digits = st_r.octet_digits + 2'd1;
            end
          end else if (text_char == CharDot) begin
            if (st_r.octet_digits == '0 || st_r.octet_value > OctetMax ||
                st_r.dot_total == 2'd3) begin
              upd.flags[FlDecBad] = 1'b1;
            end else begin
              upd.dotted_octets[st_r.dot_total] = st_r.octet_value[7:0];
              upd.dot_total = st_r.dot_total + 2'd1;
            end
            upd.octet_value  = '0;
            upd.octet_digits = '0;
          end else begin
            upd.flags[FlDecBad] = 1'b1;
          end
        end
      end
    end
  end

  assign final_state = upd;

  always_comb begin
    st_nxt = st_r;
    if (step_en) begin
      if (end_of_text) st_nxt = '0;
      else             st_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ hdl/ipatp_finish.sv @@
module ipatp_finish (
  input  ipatp_pkg::parse_state_t st,
  output logic                    parse_ok,
  output logic                    is_ipv6,
  output logic [63:0]             addr_high,
  output logic [63:0]             addr_low
);
  import ipatp_pkg::*;

  always_comb begin
    logic             ok;
    logic             failed;
    logic             dq_ok;
    logic [3:0]       hf;
    logic [3:0]       tf;
    logic [3:0]       fill;
    logic [1:0]       npush;
    logic [1:0][15:0] pv;
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [7:0][15:0] words;
    logic [2:0]       j;
    logic [4:0]       total;
    ok     = (st.text_phase != TP_LEAD) && !st.flags[FlFailed];
    failed = st.flags[FlFailed];
    dq_ok  = !st.flags[FlDecBad] && st.dot_total == 2'd3 && st.octet_digits != '0 &&
             st.octet_value <= OctetMax;
    hf    = st.head_fill;
    tf    = st.tail_fill;
    head  = st.head_groups;
    tail  = st.tail_groups;
    npush = '0;
    pv[0] = {st.dotted_octets[0], st.dotted_octets[1]};
    pv[1] = {st.dotted_octets[2], st.octet_value[7:0]};
    fill  = st.gap_seen ? tf : hf;
    words = '0;
    j     = '0;
    total = '0;
    addr_high = '0;
    addr_low  = '0;
    is_ipv6   = st.flags[FlColon];
    if (st.flags[FlColon]) begin
      if (ok) begin
        if (st.colon_phase == CP_LEAD || st.colon_phase == CP_CLOSED) begin
          ok = 1'b0;
        end else if (st.colon_phase == CP_PIECE) begin
          if (st.flags[FlDot]) begin
            if (!dq_ok || fill > 4'd6) ok = 1'b0;
            else npush = 2'd2;
          end else begin
            npush = 2'd1;
            pv[0] = st.group_value;
          end
        end
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < npush) begin
            if (st.gap_seen) begin
              if (tf[3]) failed = 1'b1;
              else begin
                tail[tf[2:0]] = pv[k];
                tf = tf + 4'd1;
              end
            end else begin
              if (hf[3]) failed = 1'b1;
              else begin
                head[hf[2:0]] = pv[k];
                hf = hf + 4'd1;
              end
            end
          end
        end
        if (failed) ok = 1'b0;
      end
      total = {1'b0, hf} + {1'b0, tf};
      if (ok) begin
        if (st.gap_seen) ok = (total < 5'd8);
        else             ok = (hf == 4'd8 && tf == '0);
      end
      if (ok) begin
        for (int i = 0; i < 8; i++) begin
          j = 3'(i) + tf[2:0];
          if (4'(i) < hf) words[i] = head[i];
          if (tf != '0 && 5'(i) >= 5'd8 - {1'b0, tf}) words[i] = tail[j];
        end
        addr_high = {words[0], words[1], words[2], words[3]};
        addr_low  = {words[4], words[5], words[6], words[7]};
      end
    end else begin
      ok = ok && dq_ok;
      if (ok) begin
        addr_low = {32'd0, st.dotted_octets[0], st.dotted_octets[1],
                    st.dotted_octets[2], st.octet_value[7:0]};
      end
    end
    parse_ok = ok;
  end

endmodule

@@ hdl/ip_address_text_parser_top.sv @@
// Channel  Ports                         Contents
// in       in_tvalid/tready/tdata/tlast  one text byte per word, tlast ends the literal
// out      out_tvalid/tready/tdata       one parse result per literal
//
// A word is accepted into an input register, from which its byte is applied
// to the parser state. One word per cycle is sustained unless a stalled output
// blocks the input; the state update is a single short step per byte. On the
// final word the post-byte state is captured into a snapshot register, the
// assembly of the address runs from that snapshot, and the result lands in
// the output register that drives out_tvalid. Reset (rst_n low, synchronous)
// empties all stages and clears the parser. A stalled output blocks the
// input only when the output register and the snapshot both hold results
// and another final word sits in the input register.
module ip_address_text_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // [7:0] text_char, [8] char_present, rest zero
  input  logic          in_tlast,   // end_of_text
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata   // [0] parse_ok, [1] is_ipv6, [65:2] addr_high,
                                    // [129:66] addr_low, rest zero
);
  import ipatp_pkg::*;

  logic         in_valid_r;
  logic [7:0]   char_r;
  logic         present_r;
  logic         last_r;
  logic         snap_valid_r;
  parse_state_t snap_r;
  parse_state_t final_state;
  logic         out_valid_r;
  logic [129:0] out_data_r;

  logic         out_free, snap_free, snap_go, step_go;
  logic         res_ok, res_v6;
  logic [63:0]  res_hi, res_lo;

  // Each stage moves on as soon as the stage behind it has room.
  assign out_free  = !out_valid_r || out_tready;
  assign snap_go   = snap_valid_r && out_free;
  assign snap_free = !snap_valid_r || out_free;
  assign step_go   = in_valid_r && (!last_r || snap_free);
  assign in_tready = !in_valid_r || step_go;

  ipatp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_go),
    .text_char    (char_r),
    .char_present (present_r),
    .end_of_text  (last_r),
    .final_state  (final_state)
  );

  ipatp_finish u_finish (
    .st        (snap_r),
    .parse_ok  (res_ok),
    .is_ipv6   (res_v6),
    .addr_high (res_hi),
    .addr_low  (res_lo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready)  in_valid_r <= in_tvalid;
      if (snap_free)  snap_valid_r <= step_go && last_r;
      if (out_free)   out_valid_r <= snap_valid_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r    <= in_tdata[7:0];
      present_r <= in_tdata[8];
      last_r    <= in_tlast;
    end
    if (step_go && last_r) snap_r <= final_state;
    if (snap_go) out_data_r <= {res_lo, res_hi, res_v6, res_ok};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule
